// ----- sv/tsm_pkg.sv -----
// Shared types and constants for the typed stack machine core.
// Depends on nothing; imported by the divider, control, datapath, top level and checker.
package tsm_pkg;

	localparam int STACK_DEPTH_DEF   = 64;
	localparam int LOCAL_SLOTS_DEF   = 16;
	localparam int POSITION_BITS_DEF = 16;
	localparam int BIN_OPERANDS      = 2;
	localparam int DATA_W            = 32;
	localparam int ENTRY_W           = DATA_W + 1;

	localparam logic [4:0] OP_PUSHINT  = 5'd0;
	localparam logic [4:0] OP_PUSHBOOL = 5'd1;
	localparam logic [4:0] OP_POP      = 5'd2;
	localparam logic [4:0] OP_LOAD     = 5'd3;
	localparam logic [4:0] OP_STORE    = 5'd4;
	localparam logic [4:0] OP_JUMP     = 5'd5;
	localparam logic [4:0] OP_JIF      = 5'd6;
	localparam logic [4:0] OP_RET      = 5'd7;
	localparam logic [4:0] OP_EQ       = 5'd8;
	localparam logic [4:0] OP_NE       = 5'd9;
	localparam logic [4:0] OP_EQI      = 5'd10;
	localparam logic [4:0] OP_NEI      = 5'd11;
	localparam logic [4:0] OP_LTI      = 5'd12;
	localparam logic [4:0] OP_GTI      = 5'd13;
	localparam logic [4:0] OP_LEI      = 5'd14;
	localparam logic [4:0] OP_GEI      = 5'd15;
	localparam logic [4:0] OP_ADD      = 5'd16;
	localparam logic [4:0] OP_SUB      = 5'd17;
	localparam logic [4:0] OP_MUL      = 5'd18;
	localparam logic [4:0] OP_DIV      = 5'd19;
	localparam logic [4:0] OP_MOD      = 5'd20;
	localparam logic [4:0] OP_NEG      = 5'd21;
	localparam logic [4:0] OP_NOT      = 5'd22;
	localparam logic [4:0] OP_AND      = 5'd23;
	localparam logic [4:0] OP_OR       = 5'd24;

	localparam logic [3:0] ST_OK     = 4'd0;
	localparam logic [3:0] ST_UNDER  = 4'd1;
	localparam logic [3:0] ST_TYPE   = 4'd2;
	localparam logic [3:0] ST_DIVZ   = 4'd3;
	localparam logic [3:0] ST_MODZ   = 4'd4;
	localparam logic [3:0] ST_LOCAL  = 4'd5;
	localparam logic [3:0] ST_OVER   = 4'd6;
	localparam logic [3:0] ST_UNSUP  = 4'd7;
	localparam logic [3:0] ST_HALTED = 4'd8;

	typedef struct packed {
		logic accept;
		logic decode;
		logic exec;
		logic fin;
		logic rf_read;
		logic rf_load;
		logic out_load;
	} tsm_cmd_t;

	typedef struct packed {
		logic div;
		logic refill;
		logic div_done;
	} tsm_stat_t;

endpackage

// ----- sv/tsm_if.sv -----
// Instruction and result channel interfaces of the typed stack machine core.
// Standalone; widths are the fixed field widths of the words.
interface tsm_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         opcode;
	logic signed [31:0] immediate_int;
	logic               immediate_bool;
	logic [7:0]         slot_index;
	logic [15:0]        jump_target;
	logic               begin_program;

	modport source (output valid, opcode, immediate_int, immediate_bool, slot_index,
		jump_target, begin_program, input ready);
	modport sink (input valid, opcode, immediate_int, immediate_bool, slot_index,
		jump_target, begin_program, output ready);
endinterface

interface tsm_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         status;
	logic [15:0]        next_position;
	logic               finished;
	logic signed [31:0] exit_code;
	logic signed [31:0] top_value;
	logic               top_is_bool;
	logic [6:0]         depth;

	modport source (output valid, status, next_position, finished, exit_code, top_value,
		top_is_bool, depth, input ready);
	modport sink (input valid, status, next_position, finished, exit_code, top_value,
		top_is_bool, depth, output ready);
endinterface

// ----- sv/tsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsm_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- sv/tsm_div.sv -----
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
// Uses tsm_pkg for the data width.
module tsm_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [tsm_pkg::DATA_W-1:0] dividend,
	input  logic [tsm_pkg::DATA_W-1:0] divisor,
	output logic                  done,
	output logic [tsm_pkg::DATA_W-1:0] quo,
	output logic [tsm_pkg::DATA_W-1:0] rem
);
	import tsm_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   trial;

	assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign trial  = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[DATA_W-1:0];
endmodule

// ----- sv/tsm_ctrl.sv -----
// Sequencing state machine of the typed stack machine core.
// Uses tsm_pkg command and status structs.
module tsm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output tsm_pkg::tsm_cmd_t  cmd,
	input  tsm_pkg::tsm_stat_t stat
);
	import tsm_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DEC  = 8'b0000_0010,
		S_EXEC = 8'b0000_0100,
		S_DIV  = 8'b0000_1000,
		S_FIN  = 8'b0001_0000,
		S_RF1  = 8'b0010_0000,
		S_RF2  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.decode   = (state_q == S_DEC);
		cmd.exec     = (state_q == S_EXEC);
		cmd.fin      = (state_q == S_FIN);
		cmd.rf_read  = (state_q == S_RF1);
		cmd.rf_load  = (state_q == S_RF2);
		cmd.out_load = (state_q == S_OUT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC:  state_d = S_EXEC;
			S_EXEC: begin
				if (stat.div) state_d = S_DIV;
				else if (stat.refill) state_d = S_RF1;
				else state_d = S_OUT;
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_FIN;
			end
			S_FIN:  state_d = S_OUT;
			S_RF1:  state_d = S_RF2;
			S_RF2:  state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ----- sv/tsm_dp.sv -----
// Datapath of the typed stack machine core: stack, locals, ALU, divider, result word.
// Uses tsm_pkg, tsm_ram and tsm_div.
module tsm_dp #(
	parameter int STACK_DEPTH   = tsm_pkg::STACK_DEPTH_DEF,
	parameter int LOCAL_SLOTS   = tsm_pkg::LOCAL_SLOTS_DEF,
	parameter int POSITION_BITS = tsm_pkg::POSITION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsm_pkg::tsm_cmd_t  cmd,
	output tsm_pkg::tsm_stat_t stat,
	input  logic [4:0]         opcode,
	input  logic [31:0]        immediate_int,
	input  logic               immediate_bool,
	input  logic [7:0]         slot_index,
	input  logic [15:0]        jump_target,
	input  logic               begin_program,
	output logic [3:0]         status,
	output logic [15:0]        next_position,
	output logic               finished,
	output logic [31:0]        exit_code,
	output logic [31:0]        top_value,
	output logic               top_is_bool,
	output logic [6:0]         depth
);
	import tsm_pkg::*;

	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int LIW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
	localparam int LCW = $clog2(LOCAL_SLOTS + 1);
	localparam int PW  = POSITION_BITS;

	// latched instruction
	logic [4:0]        op_q;
	logic [31:0]       imm_q;
	logic              immb_q;
	logic [7:0]        slot_q;
	logic [15:0]       tgt_q;

	// machine state
	logic [CW-1:0]          cnt_q;
	logic [LCW-1:0]         lcnt_q;
	logic [LOCAL_SLOTS-1:0] lvalid_q;
	logic [PW-1:0]          pos_q;
	logic                   halted_q;
	logic [ENTRY_W-1:0]     top_q;
	logic [3:0]             status_q;
	logic [31:0]            exit_q;

	logic [ENTRY_W-1:0] s_rd;
	logic [ENTRY_W-1:0] l_rd;

	logic [31:0] t_val, l_val;
	logic        t_tag, l_tag;
	logic        empty, full;
	logic [CW-1:0] cm1, cm2;
	logic [9:0]  slot_w;
	logic [LIW-1:0] lidx;
	logic [PW-1:0] tgt_pos;
	logic [31:0] mul_p;
	logic [31:0] d_quo, d_rem, div_res;
	logic        d_done;

	logic [3:0]         e_status;
	logic [31:0]        e_exit;
	logic [CW-1:0]      e_cnt;
	logic               e_wr;
	logic [SAW-1:0]     e_waddr;
	logic [ENTRY_W-1:0] e_wdata;
	logic [PW-1:0]      e_next;
	logic               e_ret;
	logic               e_lwr;
	logic [LCW-1:0]     e_lcnt;
	logic               e_div;
	logic [31:0]        b_res;
	logic               b_tag;
	logic               commit;
	logic               e_halt;

	assign t_val   = top_q[31:0];
	assign t_tag   = top_q[32];
	assign l_val   = s_rd[31:0];
	assign l_tag   = s_rd[32];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(STACK_DEPTH));
	assign cm1     = cnt_q - CW'(1);
	assign cm2     = cnt_q - CW'(BIN_OPERANDS);
	assign slot_w  = 10'(slot_q);
	assign lidx    = slot_q[LIW-1:0];
	assign tgt_pos = PW'(32'(tgt_q));
	assign mul_p   = l_val * t_val;

	always_comb begin
		if (op_q == OP_DIV) div_res = (l_val[31] ^ t_val[31]) ? (32'd0 - d_quo) : d_quo;
		else div_res = l_val[31] ? (32'd0 - d_rem) : d_rem;
	end

	always_comb begin
		e_status = ST_OK;
		e_exit   = '0;
		e_cnt    = cnt_q;
		e_wr     = 1'b0;
		e_waddr  = cnt_q[SAW-1:0];
		e_wdata  = {1'b0, imm_q};
		e_next   = pos_q + PW'(1);
		e_ret    = 1'b0;
		e_lwr    = 1'b0;
		e_lcnt   = lcnt_q;
		e_div    = 1'b0;
		b_res    = '0;
		b_tag    = 1'b0;
		case (op_q)
			OP_PUSHINT: begin
				if (full) e_status = ST_OVER;
				else begin
					e_wr  = 1'b1;
					e_cnt = cnt_q + CW'(1);
				end
			end
			OP_PUSHBOOL: begin
				e_wdata = {1'b1, 31'd0, immb_q};
				if (full) e_status = ST_OVER;
				else begin
					e_wr  = 1'b1;
					e_cnt = cnt_q + CW'(1);
				end
			end
			OP_POP: begin
				if (!empty) e_cnt = cm1;
			end
			OP_LOAD: begin
				e_wdata = lvalid_q[lidx] ? l_rd : '0;
				if (slot_w >= 10'(lcnt_q)) e_status = ST_LOCAL;
				else if (full) e_status = ST_OVER;
				else begin
					e_wr  = 1'b1;
					e_cnt = cnt_q + CW'(1);
				end
			end
			OP_STORE: begin
				if (empty) e_status = ST_UNDER;
				else begin
					e_cnt = cm1;
					if (slot_w >= 10'(LOCAL_SLOTS)) e_status = ST_LOCAL;
					else begin
						e_lwr = 1'b1;
						if (slot_w >= 10'(lcnt_q)) e_lcnt = LCW'(slot_w + 10'd1);
					end
				end
			end
			OP_JUMP: e_next = tgt_pos;
			OP_JIF: begin
				if (empty) e_status = ST_UNDER;
				else begin
					e_cnt = cm1;
					if (!t_tag) e_status = ST_TYPE;
					else if (!t_val[0]) e_next = tgt_pos;
				end
			end
			OP_RET: begin
				e_ret = 1'b1;
				if (!empty && !t_tag) e_exit = t_val;
			end
			OP_NEG, OP_NOT: begin
				e_waddr = cm1[SAW-1:0];
				e_wdata = (op_q == OP_NOT) ? {1'b1, 31'd0, ~t_val[0]} : {1'b0, 32'd0 - t_val};
				if (empty) e_status = ST_UNDER;
				else if (t_tag != (op_q == OP_NOT)) begin
					e_cnt    = cm1;
					e_status = ST_TYPE;
				end else e_wr = 1'b1;
			end
			OP_EQ, OP_NE, OP_EQI, OP_NEI, OP_LTI, OP_GTI, OP_LEI, OP_GEI, OP_ADD, OP_SUB,
			OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR: begin
				if (cnt_q < CW'(BIN_OPERANDS)) begin
					e_status = ST_UNDER;
					e_cnt    = '0;
				end else begin
					e_cnt = cm2;
					if (op_q == OP_EQ || op_q == OP_NE) begin
						if (l_tag != t_tag) e_status = ST_TYPE;
						b_res = 32'((l_val == t_val) == (op_q == OP_EQ));
						b_tag = 1'b1;
					end else if (op_q == OP_AND || op_q == OP_OR) begin
						if (!l_tag || !t_tag) e_status = ST_TYPE;
						b_res = (op_q == OP_AND) ? 32'(l_val[0] & t_val[0])
							: 32'(l_val[0] | t_val[0]);
						b_tag = 1'b1;
					end else if (l_tag || t_tag) begin
						e_status = ST_TYPE;
					end else begin
						case (op_q)
							OP_EQI: begin b_res = 32'(l_val == t_val); b_tag = 1'b1; end
							OP_NEI: begin b_res = 32'(l_val != t_val); b_tag = 1'b1; end
							OP_LTI: begin
								b_res = 32'($signed(l_val) < $signed(t_val)); b_tag = 1'b1;
							end
							OP_GTI: begin
								b_res = 32'($signed(l_val) > $signed(t_val)); b_tag = 1'b1;
							end
							OP_LEI: begin
								b_res = 32'($signed(l_val) <= $signed(t_val)); b_tag = 1'b1;
							end
							OP_GEI: begin
								b_res = 32'($signed(l_val) >= $signed(t_val)); b_tag = 1'b1;
							end
							OP_ADD: b_res = l_val + t_val;
							OP_SUB: b_res = l_val - t_val;
							OP_MUL: b_res = mul_p;
							OP_DIV, OP_MOD: begin
								if (t_val == '0) begin
									e_status = (op_q == OP_DIV) ? ST_DIVZ : ST_MODZ;
								end else begin
									b_res = div_res;
									e_div = 1'b1;
								end
							end
							default: b_res = '0;
						endcase
					end
					if (e_status == ST_OK) begin
						e_wr    = 1'b1;
						e_waddr = cm2[SAW-1:0];
						e_wdata = {b_tag, b_res};
						e_cnt   = cm1;
					end
				end
			end
			default: e_status = ST_UNSUP;
		endcase
		if (e_status != ST_OK) e_exit = 32'd1;
		if (halted_q) begin
			e_status = ST_HALTED;
			e_exit   = '0;
			e_div    = 1'b0;
		end
	end

	assign e_halt = e_ret || (e_status != ST_OK);
	assign commit = ((cmd.exec && !e_div) || cmd.fin) && !halted_q;

	always_comb begin
		stat          = '0;
		stat.div      = e_div;
		stat.refill   = !halted_q && !e_wr && (e_cnt != cnt_q) && (e_cnt != '0);
		stat.div_done = d_done;
	end

	tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (commit && e_wr),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.re    (cmd.decode || cmd.rf_read),
		.raddr (cmd.rf_read ? cm1[SAW-1:0] : cm2[SAW-1:0]),
		.rdata (s_rd)
	);

	tsm_ram #(.WIDTH(ENTRY_W), .DEPTH(LOCAL_SLOTS)) u_locals (
		.clk   (clk),
		.we    (commit && e_lwr),
		.waddr (lidx),
		.wdata (top_q),
		.re    (cmd.decode),
		.raddr (lidx),
		.rdata (l_rd)
	);

	tsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && e_div),
		.dividend (l_val[31] ? (32'd0 - l_val) : l_val),
		.divisor  (t_val[31] ? (32'd0 - t_val) : t_val),
		.done     (d_done),
		.quo      (d_quo),
		.rem      (d_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			lcnt_q   <= '0;
			lvalid_q <= '0;
			pos_q    <= '0;
			halted_q <= 1'b0;
		end else if (cmd.accept && begin_program) begin
			cnt_q    <= '0;
			lcnt_q   <= '0;
			lvalid_q <= '0;
			pos_q    <= '0;
			halted_q <= 1'b0;
		end else if (commit) begin
			cnt_q    <= e_cnt;
			halted_q <= e_halt;
			if (!e_halt) pos_q <= e_next;
			if (e_lwr) begin
				lvalid_q[lidx] <= 1'b1;
				lcnt_q         <= e_lcnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			imm_q  <= immediate_int;
			immb_q <= immediate_bool;
			slot_q <= slot_index;
			tgt_q  <= jump_target;
		end
		if (commit && e_wr) top_q <= e_wdata;
		else if (cmd.rf_load) top_q <= s_rd;
		if ((cmd.exec && !e_div) || cmd.fin) begin
			status_q <= e_status;
			exit_q   <= e_exit;
		end
		if (cmd.out_load) begin
			status        <= status_q;
			next_position <= 16'(32'(pos_q));
			finished      <= halted_q;
			exit_code     <= exit_q;
			top_value     <= empty ? 32'd0 : t_val;
			top_is_bool   <= !empty && t_tag;
			depth         <= 7'(cnt_q);
		end
	end
endmodule

// ----- sv/typed_stack_machine_core.sv -----
// Typed stack machine core: executes one bytecode word per accepted instruction and
// returns one result word. Depends on tsm_pkg, tsm_if, tsm_ctrl and tsm_dp.
//
// Sequencing: an instruction is taken only when the core is idle. Most instructions
// pass through decode, execute, result load and idle before the next instruction
// can be taken. A pop-style instruction that exposes an older stack entry adds
// refill steps that read the new top from the stack RAM. Divide and modulo run
// through a shared 32-step restoring divider, with a divide wait step and a finish
// step before the result load. The result word sits in an output register. The
// core waits in the result load step until that register is free, so a stalled
// result delays the next instruction. The operand stack and the locals live in
// RAMs with registered reads; the top of stack is held in a register. Errors and
// return halt the core; only a word with begin_program set restarts it.
module typed_stack_machine_core #(
	parameter int STACK_DEPTH   = tsm_pkg::STACK_DEPTH_DEF,
	parameter int LOCAL_SLOTS   = tsm_pkg::LOCAL_SLOTS_DEF,
	parameter int POSITION_BITS = tsm_pkg::POSITION_BITS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	tsm_in_if.sink    instr,
	tsm_out_if.source result
);
	import tsm_pkg::*;

	tsm_cmd_t  cmd;
	tsm_stat_t stat;
	logic [31:0] exit_u;
	logic [31:0] top_u;

	// sequencing
	tsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (instr.valid),
		.in_ready  (instr.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// stack, locals, ALU and the result register
	tsm_dp #(
		.STACK_DEPTH   (STACK_DEPTH),
		.LOCAL_SLOTS   (LOCAL_SLOTS),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (instr.opcode),
		.immediate_int  (instr.immediate_int),
		.immediate_bool (instr.immediate_bool),
		.slot_index     (instr.slot_index),
		.jump_target    (instr.jump_target),
		.begin_program  (instr.begin_program),
		.status         (result.status),
		.next_position  (result.next_position),
		.finished       (result.finished),
		.exit_code      (exit_u),
		.top_value      (top_u),
		.top_is_bool    (result.top_is_bool),
		.depth          (result.depth)
	);

	assign result.exit_code = $signed(exit_u);
	assign result.top_value = $signed(top_u);
endmodule

// ----- sv/tsm_checker.sv -----
// Port-level checks of the typed stack machine core, bound to the top level.
// Uses tsm_pkg status codes.
module tsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic        finished,
	input logic [31:0] exit_code,
	input logic [31:0] top_value,
	input logic        top_is_bool,
	input logic [6:0]  depth
);
	import tsm_pkg::*;

	a_halt_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_HALTED |-> finished && exit_code == 32'd0)
		else $error("halted reply without finished flag or with exit code");

	a_err_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK && status != ST_HALTED |-> finished && exit_code == 32'd1)
		else $error("error reply not halting or wrong exit code");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth == 7'd0 |-> top_value == 32'd0 && !top_is_bool)
		else $error("empty stack with nonzero top");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(depth))
		else $error("result word changed while stalled");
endmodule

bind typed_stack_machine_core tsm_checker u_tsm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.status      (result.status),
	.finished    (result.finished),
	.exit_code   (result.exit_code),
	.top_value   (result.top_value),
	.top_is_bool (result.top_is_bool),
	.depth       (result.depth)
);
